// ===== rtl/core/lrp_pkg.sv =====
// Shared types and constants for the literal response parser.
// Depends on nothing; imported by every module of the block.
package lrp_pkg;

  // Width of the length accumulator; the length saturates at all ones.
  localparam int LENGTH_BITS = 32;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Byte codes
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Status codes
  localparam logic [3:0] ST_BUSY        = 4'd0;
  localparam logic [3:0] ST_DONE        = 4'd1;
  localparam logic [3:0] ST_ERR_LEN_CR  = 4'd2;
  localparam logic [3:0] ST_ERR_LEN_LF  = 4'd3;
  localparam logic [3:0] ST_ERR_PAY_CR  = 4'd4;
  localparam logic [3:0] ST_ERR_PAY_LF  = 4'd5;
  localparam logic [3:0] ST_ERR_SKIP_LF = 4'd6;
  localparam logic [3:0] ST_ERR_END_CR  = 4'd7;
  localparam logic [3:0] ST_ERR_END_LF  = 4'd8;
  localparam logic [3:0] ST_CLOSED      = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_closed;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        length_valid;
    logic [31:0] literal_length;
    logic        payload_valid;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

// ===== rtl/core/literal_response_parser_unit.sv =====
// Literal response parser, top level: input stage, parser, result stage.
// Depends on lrp_pkg, lrp_in_reg, lrp_parser and lrp_out_reg.
//
// Usage:
//   The input stream carries one response byte per transfer (in_tdata) and
//   a stream-closed flag (in_tuser). Every accepted transfer yields exactly
//   one result transfer: status, length flag and value, payload flag and
//   byte, in arrival order.
//   An input transfer reaches out_tvalid through the input register and then
//   the result register: the parse step runs between them on the byte held
//   in the input register. Throughput is one byte per cycle while out_tready
//   is high; the parse phase and length accumulator update together for each
//   byte, with the saturating multiply-by-ten add the longest path.
//   When the receiver stalls, the result register holds its transfer and
//   the input register still takes one more byte; in_tready drops only when
//   both are full. Nothing is lost or reordered.
//   Reset (rst_n low, synchronous) empties both stages and puts the parser
//   at line start with a cleared length.
module literal_response_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] stream_closed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] status, [35:4] literal_length,
                                  // [43:36] payload_byte, [47:44] zero
  output logic [1:0]  out_tuser   // [0] length_valid, [1] payload_valid
);
  import lrp_pkg::*;

  in_item_t in_item;
  in_item_t held_item;
  logic     held_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_res;

  assign in_item.data_byte     = in_tdata;
  assign in_item.stream_closed = in_tuser[0];

  lrp_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_ready (res_ready),
    .held_item  (held_item)
  );

  lrp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (held_valid && res_ready),
    .item   (held_item),
    .result (res)
  );

  lrp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (held_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Pack the result transfer
  assign out_tdata = {4'b0, out_res.payload_byte, out_res.literal_length, out_res.status};
  assign out_tuser = {out_res.payload_valid, out_res.length_valid};

  // A held byte that cannot move on stays held
  a_held_stays: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid && !res_ready |=> held_valid && $stable(held_item))
    else $error("input stage dropped a held byte");

  // Length and payload never report on the same byte
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res.length_valid && out_res.payload_valid))
    else $error("length and payload flags both set");

  // A payload byte or a length is always reported as busy
  a_flag_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.length_valid || out_res.payload_valid)
      |-> out_res.status == ST_BUSY)
    else $error("flagged result carries a non-busy status");

  // A closed stream reports status closed
  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid && held_item.stream_closed |-> res.status == ST_CLOSED)
    else $error("closed stream not reported");

endmodule

// ===== rtl/core/lrp_in_reg.sv =====
// Input register stage of the literal response parser.
// Depends on lrp_pkg.
module lrp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lrp_pkg::in_item_t in_item,
  output logic              held_valid,
  input  logic              held_ready,
  output lrp_pkg::in_item_t held_item
);
  import lrp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Take a new transfer when empty or when the held item moves on
  assign in_ready   = !valid_r || held_ready;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== rtl/core/lrp_parser.sv =====
// Line-state tracker: parse phase, length accumulator and result logic.
// Depends on lrp_pkg.
module lrp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lrp_pkg::in_item_t item,
  output lrp_pkg::result_t  result
);
  import lrp_pkg::*;

  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_SPACE1  = 4'd1,
    PH_FIELD   = 4'd2,
    PH_BRACE   = 4'd3,
    PH_DIGITS  = 4'd4,
    PH_LEN_CR  = 4'd5,
    PH_LEN_LF  = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_PAY_CR  = 4'd8,
    PH_PAY_LF  = 4'd9,
    PH_SKIP    = 4'd10,
    PH_SKIP_LF = 4'd11,
    PH_END_CR  = 4'd12,
    PH_END_LF  = 4'd13
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic                   ended_r, ended_nxt;

  logic [7:0]             b;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [LENGTH_BITS+3:0] acc_wide;
  logic [LENGTH_BITS-1:0] left_dec;

  // Byte examined as part of a skipped line
  function automatic phase_t skip_phase(input logic [7:0] c);
    phase_t p;
    if (c == CH_CR) p = PH_SKIP_LF;
    else if (c == CH_AT) p = PH_END_CR;
    else p = PH_SKIP;
    return p;
  endfunction

  assign b        = item.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);
  // left * 10 + digit, four spare bits to detect overflow
  assign acc_wide = ({4'b0, left_r} << 3) + ({4'b0, left_r} << 1)
                    + {{LENGTH_BITS{1'b0}}, digit};
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : left_r;

  // Next state and result for the byte at hand
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    ended_nxt = ended_r;
    result    = '0;
    result.status = ST_BUSY;
    if (item.stream_closed) begin
      result.status = ST_CLOSED;
      phase_nxt = PH_START;
      left_nxt  = '0;
      ended_nxt = 1'b0;
    end else begin
      unique case (phase_r)
        PH_SPACE1: begin
          phase_nxt = (b == CH_SPACE) ? PH_FIELD : skip_phase(b);
        end
        PH_FIELD: begin
          if (b == CH_SPACE) phase_nxt = PH_BRACE;
        end
        PH_BRACE: begin
          if (b == CH_LBRACE) begin
            phase_nxt = PH_DIGITS;
            left_nxt  = '0;
            ended_nxt = 1'b0;
          end else begin
            phase_nxt = skip_phase(b);
          end
        end
        PH_DIGITS: begin
          if (b == CH_RBRACE) begin
            result.length_valid   = 1'b1;
            result.literal_length = 32'(left_r);
            ended_nxt = 1'b0;
            phase_nxt = PH_LEN_CR;
          end else if (!ended_r && is_digit) begin
            // Saturate once the product leaves the accumulator's range
            if (acc_wide > {4'b0, LEN_MAX}) left_nxt = LEN_MAX;
            else left_nxt = acc_wide[LENGTH_BITS-1:0];
          end else begin
            ended_nxt = 1'b1;
          end
        end
        PH_LEN_CR: begin
          if (b == CH_CR) begin
            phase_nxt = PH_LEN_LF;
          end else begin
            result.status = ST_ERR_LEN_CR;
            phase_nxt = PH_START;
            left_nxt  = '0;
            ended_nxt = 1'b0;
          end
        end
        PH_LEN_LF: begin
          if (b == CH_LF) begin
            phase_nxt = (left_r != '0) ? PH_PAYLOAD : PH_PAY_CR;
          end else begin
            result.status = ST_ERR_LEN_LF;
            phase_nxt = PH_START;
            left_nxt  = '0;
            ended_nxt = 1'b0;
          end
        end
        PH_PAYLOAD: begin
          result.payload_valid = 1'b1;
          result.payload_byte  = b;
          left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_PAY_CR;
        end
        PH_PAY_CR: begin
          if (b == CH_CR) begin
            phase_nxt = PH_PAY_LF;
          end else begin
            result.status = ST_ERR_PAY_CR;
            phase_nxt = PH_START;
            left_nxt  = '0;
            ended_nxt = 1'b0;
          end
        end
        PH_PAY_LF: begin
          if (b != CH_LF) result.status = ST_ERR_PAY_LF;
          phase_nxt = PH_START;
          left_nxt  = '0;
          ended_nxt = 1'b0;
        end
        PH_SKIP: begin
          phase_nxt = skip_phase(b);
        end
        PH_SKIP_LF: begin
          if (b != CH_LF) result.status = ST_ERR_SKIP_LF;
          phase_nxt = PH_START;
          left_nxt  = '0;
          ended_nxt = 1'b0;
        end
        PH_END_CR: begin
          if (b == CH_CR) begin
            phase_nxt = PH_END_LF;
          end else begin
            result.status = ST_ERR_END_CR;
            phase_nxt = PH_START;
            left_nxt  = '0;
            ended_nxt = 1'b0;
          end
        end
        PH_END_LF: begin
          result.status = (b == CH_LF) ? ST_DONE : ST_ERR_END_LF;
          phase_nxt = PH_START;
          left_nxt  = '0;
          ended_nxt = 1'b0;
        end
        default: begin
          // Line start, and any code outside the list
          phase_nxt = (b == CH_STAR) ? PH_SPACE1 : skip_phase(b);
        end
      endcase
    end
  end

  // State advances only when the held byte is handed to the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      left_r  <= '0;
      ended_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

// ===== rtl/core/lrp_out_reg.sv =====
// Result register stage of the literal response parser.
// Depends on lrp_pkg.
module lrp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  output logic             res_ready,
  input  lrp_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output lrp_pkg::result_t out_res
);
  import lrp_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Load when empty or when the waiting result is being taken
  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule
